// File: design/rbwv_pkg.sv
// Shared types and constants for the reed/bore waveguide voice.
// Holds the sequencer state type, the datapath command and status structs, and reset values.
// No dependencies; rbwv_ctrl, rbwv_datapath and the top level refer to it by scoped names.
package rbwv_pkg;

    localparam int MAX_DELAY_DEFAULT = 1024;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DELAY_W    = 10;
    localparam int LPC_W      = 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOUTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSURE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LPC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 3'd4;

    // Reset values of the configuration registers
    localparam logic signed [15:0] MOUTH_RESET   = 16'sd2949;
    localparam logic signed [15:0] CLOSURE_RESET = -16'sd3277;
    localparam logic [15:0]        SLOPE_RESET   = 16'd4096;
    localparam logic [14:0]        LPC_RESET     = 15'd9830;
    localparam int                 DELAY_RESET   = 100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLOPE,
        ST_COEF,
        ST_T1,
        ST_T2,
        ST_TSUM,
        ST_WRITE,
        ST_READ,
        ST_LP1,
        ST_LP2,
        ST_LPSUM
    } state_t;

    // Operand pair for the shared multiplier
    typedef enum logic [2:0] {
        MUL_SLOPE,
        MUL_REFL,
        MUL_MOUTH,
        MUL_DELAYED,
        MUL_LPMEM
    } mul_sel_t;

    typedef struct packed {
        logic     accept;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     coef_en;
        logic     tx_en;
        logic     mem_wr;
        logic     emit;
        logic     mem_rd;
        logic     lp_en;
    } dp_cmd_t;

    typedef struct packed {
        logic cfg_busy;
    } dp_sts_t;

endpackage

// File: design/rbwv_ctrl.sv
// Sequencer for the reed/bore waveguide voice.
// Steps one tick through the shared-multiplier schedule and owns the output valid flag.
// Depends on rbwv_pkg.
module rbwv_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rbwv_pkg::dp_sts_t sts,
    output rbwv_pkg::dp_cmd_t cmd
);

    rbwv_pkg::state_t state_reg;
    rbwv_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbwv_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbwv_pkg::ST_IDLE:
            begin
                if (in_valid && !sts.cfg_busy)
                begin
                    state_next = rbwv_pkg::ST_SLOPE;
                end
            end
            rbwv_pkg::ST_SLOPE: state_next = rbwv_pkg::ST_COEF;
            rbwv_pkg::ST_COEF:  state_next = rbwv_pkg::ST_T1;
            rbwv_pkg::ST_T1:    state_next = rbwv_pkg::ST_T2;
            rbwv_pkg::ST_T2:    state_next = rbwv_pkg::ST_TSUM;
            rbwv_pkg::ST_TSUM:  state_next = rbwv_pkg::ST_WRITE;
            rbwv_pkg::ST_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = rbwv_pkg::ST_READ;
                end
            end
            rbwv_pkg::ST_READ:  state_next = rbwv_pkg::ST_LP1;
            rbwv_pkg::ST_LP1:   state_next = rbwv_pkg::ST_LP2;
            rbwv_pkg::ST_LP2:   state_next = rbwv_pkg::ST_LPSUM;
            rbwv_pkg::ST_LPSUM: state_next = rbwv_pkg::ST_IDLE;
            default:            state_next = rbwv_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = rbwv_pkg::MUL_SLOPE;
        case (state_reg)
            rbwv_pkg::ST_IDLE:
            begin
                in_ready   = !sts.cfg_busy;
                cmd.accept = in_valid && !sts.cfg_busy;
            end
            rbwv_pkg::ST_SLOPE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rbwv_pkg::MUL_SLOPE;
            end
            rbwv_pkg::ST_COEF:
            begin
                cmd.coef_en = 1'b1;
            end
            rbwv_pkg::ST_T1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rbwv_pkg::MUL_REFL;
            end
            rbwv_pkg::ST_T2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = rbwv_pkg::MUL_MOUTH;
                cmd.acc_load = 1'b1;
            end
            rbwv_pkg::ST_TSUM:
            begin
                cmd.tx_en = 1'b1;
            end
            rbwv_pkg::ST_WRITE:
            begin
                cmd.mem_wr = slot_free;
                cmd.emit   = slot_free;
            end
            rbwv_pkg::ST_READ:
            begin
                cmd.mem_rd = 1'b1;
            end
            rbwv_pkg::ST_LP1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rbwv_pkg::MUL_DELAYED;
            end
            rbwv_pkg::ST_LP2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = rbwv_pkg::MUL_LPMEM;
                cmd.acc_load = 1'b1;
            end
            rbwv_pkg::ST_LPSUM:
            begin
                cmd.lp_en = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Raise on emit; drop once the consumer takes the transaction
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: design/rbwv_datapath.sv
// Datapath of the reed/bore waveguide voice: config registers, shared multiplier,
// accumulator, bore delay memory, lowpass and reflection state.
// Depends on rbwv_pkg; driven by rbwv_ctrl commands.
module rbwv_datapath
#(
    parameter int MAX_DELAY = rbwv_pkg::MAX_DELAY_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic [rbwv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbwv_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                blowing,
    input  rbwv_pkg::dp_cmd_t                   cmd,
    output rbwv_pkg::dp_sts_t                   sts,
    output logic signed [rbwv_pkg::SAMPLE_W-1:0] out_sample
);

    localparam int AW        = $clog2(MAX_DELAY);
    localparam int DW        = rbwv_pkg::DELAY_W;
    localparam int DLY_SPAN  = 1 << DW;
    localparam int RED_STEPS = (MAX_DELAY >= DLY_SPAN) ? 0
                             : $clog2((DLY_SPAN + MAX_DELAY - 1) / MAX_DELAY);
    localparam int STEP_W    = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;
    localparam logic [DW-1:0] DLY_RESET_RED = DW'(rbwv_pkg::DELAY_RESET % MAX_DELAY);
    localparam logic [AW:0]   MAX_EXT       = (AW+1)'(MAX_DELAY);
    localparam logic [AW-1:0] WP_LAST       = AW'(MAX_DELAY - 1);

    // Configuration
    logic signed [15:0] mouth_reg;
    logic signed [15:0] closure_reg;
    logic [15:0]        slope_reg;
    logic [14:0]        lpc_reg;
    logic [DW-1:0]      dly_rem_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [31:0]        red_sub;
    logic               red_busy;

    // Tick state
    logic signed [15:0] refl_reg;
    logic signed [15:0] lpm_reg;
    logic [AW-1:0]      wp_reg;
    logic               full_reg;

    // Working registers
    logic               blow_reg;
    logic signed [35:0] prod_reg;
    logic signed [35:0] acc_reg;
    logic signed [16:0] coef_reg;
    logic signed [16:0] coef_next;
    logic signed [15:0] tx_reg;
    logic signed [15:0] out_sample_reg;
    logic signed [15:0] rdata_reg;
    logic               rvalid_reg;

    logic signed [15:0] bore_mem [MAX_DELAY];

    logic signed [15:0] mouth;
    logic signed [17:0] delta;
    logic signed [17:0] closure_ext;
    logic signed [17:0] diff_full;
    logic               below;
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] product;
    logic signed [35:0] coef_shift;
    logic signed [35:0] coef_cand;
    logic signed [35:0] sum;
    logic signed [35:0] rnd;
    logic signed [15:0] sum_sat;
    logic signed [15:0] refl_new;
    logic signed [15:0] delayed;
    logic [AW-1:0]      d_addr;
    logic [AW:0]        rd_sum;
    logic [AW-1:0]      rd_addr;
    logic               rd_valid;

    assign red_busy     = (step_reg != '0);
    assign sts.cfg_busy = red_busy;
    assign red_sub      = 32'(MAX_DELAY) << (step_reg - STEP_W'(1));

    // Config writes stall the delay's one bit per cycle reduction modulo the line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mouth_reg   <= rbwv_pkg::MOUTH_RESET;
            closure_reg <= rbwv_pkg::CLOSURE_RESET;
            slope_reg   <= rbwv_pkg::SLOPE_RESET;
            lpc_reg     <= rbwv_pkg::LPC_RESET;
            dly_rem_reg <= DLY_RESET_RED;
            step_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                rbwv_pkg::CFG_MOUTH:   mouth_reg   <= cfg_data;
                rbwv_pkg::CFG_CLOSURE: closure_reg <= cfg_data;
                rbwv_pkg::CFG_SLOPE:   slope_reg   <= cfg_data;
                rbwv_pkg::CFG_LPC:     lpc_reg     <= cfg_data[14:0];
                rbwv_pkg::CFG_DELAY:
                begin
                    dly_rem_reg <= cfg_data[DW-1:0];
                    step_reg    <= STEP_W'(RED_STEPS);
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
        end
        else if (red_busy)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (32'(dly_rem_reg) >= red_sub)
            begin
                dly_rem_reg <= DW'(32'(dly_rem_reg) - red_sub);
            end
        end
    end

    // Reed rule front end
    assign mouth       = blow_reg ? mouth_reg : 16'sd0;
    assign delta       = {{2{refl_reg[15]}}, refl_reg} - {{2{mouth[15]}}, mouth};
    assign closure_ext = {{2{closure_reg[15]}}, closure_reg};
    assign below       = (delta < closure_ext);
    assign diff_full   = delta - closure_ext;

    assign delayed = rvalid_reg ? rdata_reg : 16'sd0;

    always_comb
    begin
        case (cmd.mul_sel)
            rbwv_pkg::MUL_SLOPE:
            begin
                mul_a = {2'b00, slope_reg};
                mul_b = {1'b0, diff_full[16:0]};
            end
            rbwv_pkg::MUL_REFL:
            begin
                mul_a = {coef_reg[16], coef_reg};
                mul_b = {{2{refl_reg[15]}}, refl_reg};
            end
            rbwv_pkg::MUL_MOUTH:
            begin
                mul_a = 18'sd32768 - {coef_reg[16], coef_reg};
                mul_b = {{2{mouth[15]}}, mouth};
            end
            rbwv_pkg::MUL_DELAYED:
            begin
                mul_a = 18'sd32768 - {3'b000, lpc_reg};
                mul_b = {{2{delayed[15]}}, delayed};
            end
            rbwv_pkg::MUL_LPMEM:
            begin
                mul_a = {3'b000, lpc_reg};
                mul_b = {{2{lpm_reg[15]}}, lpm_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Coefficient: 1 below closure, else 1 - rounded slope product, floored at -1
    assign coef_shift = (prod_reg + 36'sd2048) >>> 12;
    assign coef_cand  = 36'sd32768 - coef_shift;

    always_comb
    begin
        if (below)
        begin
            coef_next = 17'sd32768;
        end
        else if (coef_cand < -36'sd32768)
        begin
            coef_next = -17'sd32768;
        end
        else
        begin
            coef_next = coef_cand[16:0];
        end
    end

    // Shared round-half-up and saturate of the two-product sum
    assign sum = acc_reg + prod_reg;
    assign rnd = (sum + 36'sd16384) >>> 15;

    always_comb
    begin
        if (rnd > 36'sd32767)
        begin
            sum_sat = 16'sd32767;
        end
        else if (rnd < -36'sd32768)
        begin
            sum_sat = -16'sd32768;
        end
        else
        begin
            sum_sat = rnd[15:0];
        end
    end

    assign refl_new = (sum_sat == -16'sd32768) ? 16'sd32767 : -sum_sat;

    // Read address wp - d, wrapped into the line
    assign d_addr   = AW'(dly_rem_reg);
    assign rd_sum   = {1'b0, wp_reg} + MAX_EXT - {1'b0, d_addr};
    assign rd_addr  = (rd_sum >= MAX_EXT) ? AW'(rd_sum - MAX_EXT) : rd_sum[AW-1:0];
    assign rd_valid = full_reg || (rd_addr <= wp_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            blow_reg <= blowing;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= product;
        end
        if (cmd.acc_load)
        begin
            acc_reg <= prod_reg;
        end
        if (cmd.coef_en)
        begin
            coef_reg <= coef_next;
        end
        if (cmd.tx_en)
        begin
            tx_reg <= sum_sat;
        end
        if (cmd.emit)
        begin
            out_sample_reg <= tx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            bore_mem[wp_reg] <= tx_reg;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg  <= bore_mem[rd_addr];
            rvalid_reg <= rd_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refl_reg <= '0;
            lpm_reg  <= '0;
            wp_reg   <= '0;
            full_reg <= 1'b0;
        end
        else if (cmd.lp_en)
        begin
            lpm_reg  <= sum_sat;
            refl_reg <= refl_new;
            if (wp_reg == WP_LAST)
            begin
                wp_reg   <= '0;
                full_reg <= 1'b1;
            end
            else
            begin
                wp_reg <= wp_reg + AW'(1);
            end
        end
    end

    assign out_sample = out_sample_reg;

endmodule

// File: design/reed_bore_waveguide_voice.sv
// Top level of the reed/bore waveguide voice: ties the sequencer to the datapath.
// Depends on rbwv_pkg, rbwv_ctrl and rbwv_datapath.
//
//   channel | handshake              | payload                        | direction
//   --------+------------------------+--------------------------------+----------
//   input   | in_valid / in_ready    | blowing (1b)                   | in
//   output  | out_valid / out_ready  | out_sample (16b signed Q1.15)  | out
//   config  | cfg_valid / cfg_ready  | cfg_index (3b), cfg_data (16b) | in
//
// One tick, from acceptance to the next acceptance, makes five passes through
// the single shared 18x18 multiplier, two round/saturate sums, and a separate memory
// write then read so a zero delay returns the sample just written.
// The result is registered; a pending result holds only the write step of the next tick.
// Reset: async, active low. No clearing pass: a wrap flag marks the line as filled.
// After a delay_length write, in_ready stays low while the delay is reduced modulo
// MAX_DELAY, one step per cycle, held by config writes (0 steps if >= 1024, 6 at 16).
module reed_bore_waveguide_voice
#(
    parameter int MAX_DELAY = rbwv_pkg::MAX_DELAY_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 blowing,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rbwv_pkg::SAMPLE_W-1:0] out_sample,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rbwv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rbwv_pkg::CFG_DATA_W-1:0]      cfg_data
);

    rbwv_pkg::dp_cmd_t cmd;
    rbwv_pkg::dp_sts_t sts;

    // Config transactions are always taken; user must write only while idle (unenforced)
    assign cfg_ready = 1'b1;

    rbwv_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rbwv_datapath
    #(
        .MAX_DELAY (MAX_DELAY)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .blowing    (blowing),
        .cmd        (cmd),
        .sts        (sts),
        .out_sample (out_sample)
    );

endmodule

// File: design/rbwv_checker.sv
// Port-level checks for the reed/bore waveguide voice, bound to the top level.
// Depends only on the top-level ports.
module rbwv_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_sample
);

    // A pending result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before transaction completed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_sample))
        else $error("out_sample changed while stalled");

    // A tick occupies the block: in_ready drops after an accepted input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input taken while a tick is in progress");

    // A new result appears only from a tick in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised outside a tick");

endmodule

bind reed_bore_waveguide_voice rbwv_checker u_rbwv_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample)
);
